// ----- rtl/bounded_integer_set_defines.svh -----
// assertion macros for the port-level checker
`ifndef BOUNDED_INTEGER_SET_DEFINES_SVH
`define BOUNDED_INTEGER_SET_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BIS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BIS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bis_pkg.sv -----
// types and codes of the bounded integer set
package bis_pkg;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_CLEAR  = 2'd3
  } bis_action_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_CLEAR
  } bis_state_t;

  typedef struct packed {
    bis_action_t        action;
    logic signed [31:0] value;
  } bis_in_t;

  typedef struct packed {
    logic       was_member;
    logic [4:0] element_count;
    logic       set_empty;
    logic       rejected;
  } bis_out_t;

  // one slot word as kept in the memory
  typedef struct packed {
    logic        valid;
    logic [31:0] value;
  } bis_slot_t;

endpackage

// ----- rtl/bounded_integer_set.sv -----
// Set of up to CAPACITY distinct 32-bit integers, one slot per element in a memory.
// Each action reads all CAPACITY slots, one per cycle through the single read port,
// then writes at most one slot; clear instead sweeps every slot to invalid.
// A new start is taken in the strobe cycle, except after clear, whose invalidating
// sweep writes one slot a cycle and keeps busy high past the strobe.
// After reset busy stays high while every slot is marked free.
module bounded_integer_set #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bis_pkg::bis_in_t  in_data,
  output logic              out_valid,
  output bis_pkg::bis_out_t out_data
);

  localparam int AW = $clog2(CAPACITY);

  logic               mem_rd_en;
  logic [AW-1:0]      mem_rd_addr;
  logic               mem_wr_en;
  logic [AW-1:0]      mem_wr_addr;
  bis_pkg::bis_slot_t mem_wr_word;
  bis_pkg::bis_slot_t mem_rd_word;

  bis_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_data     (in_data),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_word (mem_wr_word),
    .mem_rd_word (mem_rd_word)
  );

  bis_slot_mem #(
    .DEPTH(CAPACITY)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_word (mem_wr_word),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_word (mem_rd_word)
  );

endmodule

// ----- rtl/bis_slot_mem.sv -----
// slot memory: one write port, one registered read port
module bis_slot_mem #(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  bis_pkg::bis_slot_t wr_word,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output bis_pkg::bis_slot_t rd_word
);

  bis_pkg::bis_slot_t mem [DEPTH];
  bis_pkg::bis_slot_t rd_word_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  assign rd_word = rd_word_r;

endmodule

// ----- rtl/bis_ctrl.sv -----
// scan sequencer: walks all slots, then writes at most one slot (clear sweeps all) and updates the count
module bis_ctrl #(
  parameter int CAPACITY = 16,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  bis_pkg::bis_in_t   in_data,
  output logic               busy,
  output logic               out_valid,
  output bis_pkg::bis_out_t  out_data,
  output logic               mem_rd_en,
  output logic [AW-1:0]      mem_rd_addr,
  output logic               mem_wr_en,
  output logic [AW-1:0]      mem_wr_addr,
  output bis_pkg::bis_slot_t mem_wr_word,
  input  bis_pkg::bis_slot_t mem_rd_word
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

  bis_pkg::bis_state_t  state_r, state_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;

  bis_pkg::bis_action_t act_r, act_nxt;
  logic [31:0]          val_r, val_nxt;
  logic                 hit_r, hit_nxt;
  logic [AW-1:0]        hit_idx_r, hit_idx_nxt;
  logic                 free_r, free_nxt;
  logic [AW-1:0]        free_idx_r, free_idx_nxt;
  bis_pkg::bis_out_t    out_r, out_nxt;

  logic                 slot_match;
  logic                 slot_free;
  logic                 rej;

  assign slot_match = mem_rd_word.valid && (mem_rd_word.value == val_r);
  assign slot_free  = !mem_rd_word.valid;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    act_nxt       = act_r;
    val_nxt       = val_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    out_nxt       = out_r;
    rej           = 1'b0;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = idx_r + AW'(1);
    mem_wr_en     = 1'b0;
    mem_wr_addr   = idx_r;
    mem_wr_word   = '0;

    unique case (state_r)
      bis_pkg::ST_INIT, bis_pkg::ST_CLEAR: begin
        // sweep every slot to invalid
        mem_wr_en = 1'b1;
        if (idx_r == LAST) begin
          idx_nxt   = '0;
          state_nxt = bis_pkg::ST_IDLE;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      bis_pkg::ST_IDLE: begin
        if (start) begin
          act_nxt     = in_data.action;
          val_nxt     = in_data.value;
          hit_nxt     = 1'b0;
          free_nxt    = 1'b0;
          idx_nxt     = '0;
          mem_rd_en   = 1'b1;
          mem_rd_addr = '0;
          state_nxt   = bis_pkg::ST_SCAN;
        end
      end
      bis_pkg::ST_SCAN: begin
        // read data here belongs to slot idx_r
        if (slot_match) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = idx_r;
        end
        if (slot_free && !free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = idx_r;
        end
        if (idx_r == LAST) begin
          state_nxt = bis_pkg::ST_APPLY;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          mem_rd_en = 1'b1;
        end
      end
      bis_pkg::ST_APPLY: begin
        out_valid_nxt = 1'b1;
        idx_nxt       = '0;
        state_nxt     = bis_pkg::ST_IDLE;
        case (act_r)
          bis_pkg::ACT_ADD: begin
            if (!hit_r) begin
              if (free_r) begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = free_idx_r;
                mem_wr_word = '{valid: 1'b1, value: val_r};
                count_nxt   = count_r + CW'(1);
              end else begin
                rej = 1'b1;
              end
            end
          end
          bis_pkg::ACT_REMOVE: begin
            if (hit_r) begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = hit_idx_r;
              count_nxt   = count_r - CW'(1);
            end
          end
          bis_pkg::ACT_CLEAR: begin
            count_nxt = '0;
            state_nxt = bis_pkg::ST_CLEAR;
          end
          default: begin
          end
        endcase
        out_nxt.was_member    = hit_r;
        out_nxt.element_count = 5'(count_nxt);
        out_nxt.set_empty     = (count_nxt == '0);
        out_nxt.rejected      = rej;
      end
      default: begin
        state_nxt = bis_pkg::ST_INIT;
        idx_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bis_pkg::ST_INIT;
      idx_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    val_r      <= val_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    out_r      <= out_nxt;
  end

  assign busy      = (state_r != bis_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/bis_checker.sv -----
// port-level checker for the bounded integer set, bound to the top level
`include "bounded_integer_set_defines.svh"

module bis_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input bis_pkg::bis_in_t  in_data,
  input logic              out_valid,
  input bis_pkg::bis_out_t out_data
);

  logic in_xfer;
  assign in_xfer = start && !busy && (in_data.value == in_data.value);

  // an accepted transfer keeps the block busy while it scans
  `BIS_ASSERT_NXT(a_busy_after_xfer, in_xfer, busy, "no busy after accepted transfer")
  // one strobe per result, never two in a row
  `BIS_ASSERT_NXT(a_single_strobe, out_valid, !out_valid, "result strobe held two cycles")
  `BIS_ASSERT_IMP(a_empty_count, out_valid && out_data.set_empty,
    out_data.element_count == 5'd0, "empty flag with nonzero count")
  `BIS_ASSERT_IMP(a_reject_absent, out_valid && out_data.rejected,
    !out_data.was_member, "rejected add of a present value")

endmodule

bind bounded_integer_set bis_checker u_bis_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ----- test/bounded_integer_set_tb.sv -----
// self-checking testbench for the bounded integer set: directed edges, full-set and random actions
module bounded_integer_set_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bis_pkg::*;

  localparam int SLOTS = 16;
  // clear is the slowest action: scan plus invalidating sweep
  localparam int ACTION_LATENCY = 2 * SLOTS + 2;
  localparam int MAX_GAP = 40;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  bis_in_t  in_data = '0;
  logic     out_valid;
  bis_out_t out_data;

  // mirror of the table contents
  logic [31:0] mirror_values [SLOTS];
  bit          mirror_used [SLOTS];
  int          mirror_count = 0;

  bis_out_t pending_answers[$];
  int       answer_errors = 0;
  int       answers_checked = 0;
  int       actions_sent [4] = '{0, 0, 0, 0};
  int       rejects_predicted = 0;
  int       hits_predicted = 0;
  bit       idle_enabled = 1'b1;

  always #5 clk = ~clk;

  bounded_integer_set #(.CAPACITY(SLOTS)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  function automatic bis_out_t predict_set_action(bis_action_t act, logic [31:0] v);
    bis_out_t ans;
    int hit;
    int free_slot;
    hit = -1;
    free_slot = -1;
    ans = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (mirror_used[i] && mirror_values[i] == v && hit < 0) hit = i;
      if (!mirror_used[i] && free_slot < 0) free_slot = i;
    end
    ans.was_member = (hit >= 0);
    case (act)
      ACT_ADD: begin
        if (hit < 0) begin
          if (free_slot >= 0) begin
            mirror_values[free_slot] = v;
            mirror_used[free_slot] = 1'b1;
            mirror_count++;
          end else begin
            ans.rejected = 1'b1;
          end
        end
      end
      ACT_REMOVE: begin
        if (hit >= 0) begin
          mirror_used[hit] = 1'b0;
          if (mirror_count > 0) mirror_count--;
        end
      end
      ACT_QUERY: begin
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) mirror_used[i] = 1'b0;
        mirror_count = 0;
      end
    endcase
    ans.element_count = mirror_count[4:0];
    ans.set_empty = (mirror_count == 0);
    if (ans.rejected) rejects_predicted++;
    if (ans.was_member) hits_predicted++;
    return ans;
  endfunction

  // one transfer on the command side; start is left high for a back-to-back follower
  task automatic send_action(bis_action_t act, logic [31:0] v);
    int gap;
    if (idle_enabled && $urandom_range(99) < 24) begin
      gap = $urandom_range(1, MAX_GAP);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= '{action: act, value: v};
    do @(posedge clk); while (busy);
    pending_answers.push_back(predict_set_action(act, v));
    actions_sent[act]++;
  endtask

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    answer_errors++;
    if (answer_errors <= 10)
      $display("mismatch in %s at %0t ns: expected %0d, got %0d", what, $realtime, want, got);
  endtask

  always @(posedge clk) begin
    bis_out_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unrequested result", 0, 1);
      end else begin
        want = pending_answers.pop_front();
        answers_checked++;
        if (out_data.was_member !== want.was_member)
          report_mismatch("was_member", want.was_member, out_data.was_member);
        if (out_data.element_count !== want.element_count)
          report_mismatch("element_count", want.element_count, out_data.element_count);
        if (out_data.set_empty !== want.set_empty)
          report_mismatch("set_empty", want.set_empty, out_data.set_empty);
        if (out_data.rejected !== want.rejected)
          report_mismatch("rejected", want.rejected, out_data.rejected);
      end
    end
  end

  function automatic logic [31:0] edge_or_random_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic bit value_in_list(logic [31:0] v, ref logic [31:0] list[$]);
    foreach (list[i]) if (list[i] == v) return 1'b1;
    return 1'b0;
  endfunction

  task automatic test_edge_values();
    send_action(ACT_QUERY, 32'h0000_0000);
    send_action(ACT_REMOVE, 32'h0000_0000);
    send_action(ACT_ADD, 32'h8000_0000);
    send_action(ACT_ADD, 32'h7fff_ffff);
    send_action(ACT_ADD, 32'h0000_0000);
    send_action(ACT_ADD, 32'hffff_ffff);
    // add of a present value leaves the set alone
    send_action(ACT_ADD, 32'h7fff_ffff);
    send_action(ACT_QUERY, 32'h8000_0000);
    // differs in one bit only
    send_action(ACT_QUERY, 32'h8000_0001);
    send_action(ACT_REMOVE, 32'h0001_2345);
    send_action(ACT_REMOVE, 32'h7fff_ffff);
    send_action(ACT_QUERY, 32'h7fff_ffff);
    // clear still reports prior membership of its value
    send_action(ACT_CLEAR, 32'h0000_0000);
    send_action(ACT_QUERY, 32'h0000_0000);
    send_action(ACT_CLEAR, 32'hffff_ffff);
    send_action(ACT_ADD, 32'h5555_aaaa);
  endtask

  task automatic test_full_set(int rounds);
    logic [31:0] members[$];
    logic [31:0] v;
    repeat (rounds) begin
      send_action(ACT_CLEAR, $urandom());
      members.delete();
      while (members.size() < SLOTS) begin
        v = edge_or_random_value();
        if (!value_in_list(v, members)) members.push_back(v);
      end
      foreach (members[i]) send_action(ACT_ADD, members[i]);
      // a new value now finds every slot in use
      repeat (2) begin
        do v = $urandom(); while (value_in_list(v, members));
        send_action(ACT_ADD, v);
      end
      send_action(ACT_ADD, members[$urandom_range(SLOTS - 1)]);
      send_action(ACT_QUERY, members[$urandom_range(SLOTS - 1)]);
      // free one slot, refill it, then the set is full again
      send_action(ACT_REMOVE, members[$urandom_range(SLOTS - 1)]);
      do v = $urandom(); while (value_in_list(v, members));
      send_action(ACT_ADD, v);
      members.push_back(v);
      do v = $urandom(); while (value_in_list(v, members));
      send_action(ACT_ADD, v);
    end
  endtask

  task automatic test_random_actions(int item_total);
    logic [31:0] value_pool[$];
    int sent;
    int run_len;
    int add_pct;
    int pick;
    logic [31:0] v;
    bis_action_t act;
    sent = 0;
    while (sent < item_total) begin
      value_pool.delete();
      repeat ($urandom_range(2, 24)) value_pool.push_back(edge_or_random_value());
      run_len = $urandom_range(20, 60);
      add_pct = $urandom_range(30, 70);
      repeat (run_len) begin
        // a long back-to-back stretch in the middle of the whole test
        idle_enabled = !(sent >= item_total / 3 && sent < item_total / 2);
        pick = $urandom_range(99);
        if (pick < 2) act = ACT_CLEAR;
        else if (pick < add_pct) act = ACT_ADD;
        else if (pick < add_pct + (100 - add_pct) / 2) act = ACT_REMOVE;
        else act = ACT_QUERY;
        if ($urandom_range(9) == 0) v = $urandom();
        else v = value_pool[$urandom_range(value_pool.size() - 1)];
        send_action(act, v);
        sent++;
      end
    end
    idle_enabled = 1'b1;
  endtask

  initial begin
    int waited;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edge_values();
    test_full_set(3);
    test_random_actions(560);

    start <= 1'b0;
    waited = 0;
    while (pending_answers.size() != 0 && waited < 100 * ACTION_LATENCY) begin
      @(posedge clk);
      waited++;
    end
    repeat (ACTION_LATENCY) @(posedge clk);
    if (pending_answers.size() != 0) begin
      $display("%0d results never arrived", pending_answers.size());
      answer_errors += pending_answers.size();
    end

    $display("covered %0d adds (%0d into a full set), %0d removes, %0d queries, %0d clears",
             actions_sent[ACT_ADD], rejects_predicted, actions_sent[ACT_REMOVE],
             actions_sent[ACT_QUERY], actions_sent[ACT_CLEAR]);
    $display("%0d results checked, %0d on values already present, %0d mismatches",
             answers_checked, hits_predicted, answer_errors);
    if (answer_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout: run did not complete");
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/bis_pkg.sv
rtl/bis_slot_mem.sv
rtl/bis_ctrl.sv
rtl/bounded_integer_set.sv
rtl/bis_checker.sv
test/bounded_integer_set_tb.sv
